// ----- design/jdc_pkg.sv -----
// jdc_pkg: shared types, codes and constants for the Julian day converter
// used by jdc_datapath and julian_day_converter; no dependencies
`default_nettype none

package jdc_pkg;

  localparam int unsigned YEAR_BITS = 16;

  // opcodes
  localparam logic OP_TO_JD  = 1'b0;
  localparam logic OP_TO_CAL = 1'b1;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_MONTH = 2'd1;
  localparam logic [1:0] ST_BAD_FIELD = 2'd2;
  localparam logic [1:0] ST_BAD_YEAR  = 2'd3;

  localparam logic [26:0] MS_PER_DAY = 27'd86400000;
  localparam logic [25:0] JD_OFS_IN  = 26'd32044;
  localparam logic [25:0] JD_OFS_OUT = 26'd32045;
  localparam logic [17:0] YEAR_OFS   = 18'd4800;

  // reciprocal constants: floor(2^K / D), the quotient estimate is low by at most one
  localparam int unsigned    DIV100_K  = 24;
  localparam logic [17:0]    DIV100_M  = 18'((64'd1 << DIV100_K) / 64'd100);
  localparam int unsigned    DIV146097_K = 46;
  localparam logic [28:0]    DIV146097_M = 29'((64'd1 << DIV146097_K) / 64'd146097);
  localparam int unsigned    DIV1461_K = 29;
  localparam logic [18:0]    DIV1461_M = 19'((64'd1 << DIV1461_K) / 64'd1461);
  localparam int unsigned    DIV153_K  = 19;
  localparam logic [11:0]    DIV153_M  = 12'((64'd1 << DIV153_K) / 64'd153);
  localparam int unsigned    DIV1000_K = 37;
  localparam logic [27:0]    DIV1000_M = 28'((64'd1 << DIV1000_K) / 64'd1000);
  localparam int unsigned    DIV60_K   = 23;
  localparam logic [17:0]    DIV60_M   = 18'((64'd1 << DIV60_K) / 64'd60);

  typedef struct packed {
    logic        opcode;
    logic [15:0] year;
    logic [3:0]  month;
    logic [4:0]  day_of_month;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [9:0]  millisecond;
    logic [24:0] jd_day;
    logic [26:0] time_ms;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [24:0] out_jd_day;
    logic [26:0] out_time_ms;
    logic [15:0] out_year;
    logic [3:0]  out_month;
    logic [4:0]  out_day;
    logic [4:0]  out_hour;
    logic [5:0]  out_minute;
    logic [5:0]  out_second;
    logic [9:0]  out_millisecond;
  } out_t;

  // days in a month
  function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
    logic [4:0] len;
    unique case (mon)
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

  // days before shifted month m (march based), (153 m + 2) / 5
  function automatic logic [8:0] month_start(input logic [3:0] m);
    logic [8:0] days;
    unique case (m)
      4'd0:    days = 9'd0;
      4'd1:    days = 9'd31;
      4'd2:    days = 9'd61;
      4'd3:    days = 9'd92;
      4'd4:    days = 9'd122;
      4'd5:    days = 9'd153;
      4'd6:    days = 9'd184;
      4'd7:    days = 9'd214;
      4'd8:    days = 9'd245;
      4'd9:    days = 9'd275;
      4'd10:   days = 9'd306;
      4'd11:   days = 9'd337;
      default: days = 9'd0;
    endcase
    return days;
  endfunction

endpackage

`default_nettype wire

// ----- design/julian_day_converter.sv -----
// julian_day_converter: top level, pipeline enable and output register
// depends on jdc_pkg and jdc_datapath
//
//   channel | direction | handshake          | word
//   in_     | input     | in_valid/in_stall   | jdc_pkg::in_t
//   out_    | output    | out_valid/out_stall | jdc_pkg::out_t
//
// one word per cycle while out_stall is not holding back a result; seven datapath stages and the output register
// the stage count follows from the chain of constant divisions of the day number
// synchronous active-low reset clears all valid bits
// out_stall with a waiting result freezes every stage; in_stall follows it
`default_nettype none

module julian_day_converter (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire jdc_pkg::in_t in_data,
  output logic              out_valid,
  input  wire logic         out_stall,
  output jdc_pkg::out_t     out_data
);
  import jdc_pkg::*;

  logic en;
  logic res_valid;
  out_t res_word;
  logic out_valid_r;
  out_t out_data_r;

  // advance unless a result is held back
  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  jdc_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .in_word   (in_data),
    .res_valid (res_valid),
    .res_word  (res_word)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= res_word;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ----- design/jdc_datapath.sv -----
// jdc_datapath: seven register stages of both conversions plus the final result logic
// depends on jdc_pkg
`default_nettype none

module jdc_datapath (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         en,
  input  wire logic         in_valid,
  input  wire jdc_pkg::in_t in_word,
  output logic              res_valid,
  output jdc_pkg::out_t     res_word
);
  import jdc_pkg::*;

  // stage 1
  logic        s1_v_r, s1_op_r, s1_mon_bad_r, s1_time_bad_r, s1_year_big_r, s1_tbad_r;
  logic [15:0] s1_year_r;
  logic [4:0]  s1_day_r;
  logic [3:0]  s1_mm_r, s1_mon_r;
  logic [16:0] s1_y_r;
  logic [10:0] s1_hm_r;
  logic [5:0]  s1_sec_r;
  logic [9:0]  s1_ms_r;
  logic [27:0] s1_x1_r;
  logic [26:0] s1_t_r;
  // stage 2
  logic        s2_v_r, s2_op_r, s2_mon_bad_r, s2_time_bad_r, s2_year_big_r, s2_tbad_r;
  logic [15:0] s2_year_r;
  logic [4:0]  s2_day_r;
  logic [3:0]  s2_mm_r, s2_mon_r;
  logic [16:0] s2_y_r;
  logic [34:0] s2_pyr_r, s2_py_r;
  logic [16:0] s2_hms_r;
  logic [9:0]  s2_ms_r;
  logic [56:0] s2_p1_r;
  logic [27:0] s2_x1_r;
  logic [54:0] s2_pt_r;
  logic [26:0] s2_t_r;
  // stage 3
  logic        s3_v_r, s3_op_r, s3_mon_bad_r, s3_time_bad_r, s3_year_big_r, s3_tbad_r;
  logic [1:0]  s3_year_lo_r;
  logic [4:0]  s3_day_r;
  logic [3:0]  s3_mm_r, s3_mon_r;
  logic [16:0] s3_y_r;
  logic        s3_c100_r;
  logic [1:0]  s3_qyr_lo_r;
  logic [10:0] s3_qy_r;
  logic [26:0] s3_tms_r;
  logic [10:0] s3_b_r;
  logic [15:0] s3_c_r;
  logic [16:0] s3_secs_r;
  logic [9:0]  s3_msr_r;
  // stage 4
  logic        s4_v_r, s4_op_r, s4_tbad_r;
  logic [1:0]  s4_st0_r;
  logic [25:0] s4_jda_r;
  logic [9:0]  s4_jdb_r;
  logic [10:0] s4_qy_r;
  logic [26:0] s4_tms_r;
  logic [10:0] s4_b_r;
  logic [17:0] s4_x2_r;
  logic [36:0] s4_p2_r;
  logic [34:0] s4_psec_r;
  logic [16:0] s4_secs_r;
  logic [9:0]  s4_msr_r;
  // stage 5
  logic        s5_v_r, s5_op_r, s5_tbad_r;
  logic [1:0]  s5_st0_r;
  logic [24:0] s5_jd_r;
  logic [26:0] s5_tms_r;
  logic [10:0] s5_b_r;
  logic [7:0]  s5_d_r;
  logic [8:0]  s5_e_r;
  logic [11:0] s5_mint_r;
  logic [5:0]  s5_sec_r;
  logic [9:0]  s5_msr_r;
  // stage 6
  logic        s6_v_r, s6_op_r, s6_tbad_r;
  logic [1:0]  s6_st0_r;
  logic [24:0] s6_jd_r;
  logic [26:0] s6_tms_r;
  logic [10:0] s6_b_r;
  logic [7:0]  s6_d_r;
  logic [10:0] s6_x3_r;
  logic [22:0] s6_p3_r;
  logic [34:0] s6_pmin_r;
  logic [11:0] s6_mint_r;
  logic [5:0]  s6_sec_r;
  logic [9:0]  s6_msr_r;
  // stage 7
  logic        s7_v_r, s7_op_r, s7_tbad_r;
  logic [1:0]  s7_st0_r;
  logic [24:0] s7_jd_r;
  logic [26:0] s7_tms_r;
  logic [10:0] s7_b_r;
  logic [7:0]  s7_d_r;
  logic [3:0]  s7_m_r;
  logic [7:0]  s7_r3_r;
  logic [4:0]  s7_hour_r;
  logic [5:0]  s7_min_r;
  logic [5:0]  s7_sec_r;
  logic [9:0]  s7_msr_r;

  // stage 1 front end
  logic        a_flag;
  logic [25:0] a_cal;
  assign a_flag = (in_word.month <= 4'd2);
  assign a_cal  = 26'(in_word.jd_day) + JD_OFS_IN;

  // stage 3 quotient corrections
  logic [10:0] qyr_nxt, qy_nxt, b_nxt;
  logic [16:0] ryr_nxt, ry_nxt, secs_nxt;
  logic [27:0] r1_nxt;
  logic [26:0] rms_nxt;
  always_comb begin
    qyr_nxt = s2_pyr_r[DIV100_K +: 11];
    ryr_nxt = 17'(s2_year_r) - 17'(qyr_nxt) * 17'd100;
    if (ryr_nxt >= 17'd100) begin
      qyr_nxt = qyr_nxt + 11'd1;
      ryr_nxt = ryr_nxt - 17'd100;
    end
    qy_nxt = s2_py_r[DIV100_K +: 11];
    ry_nxt = s2_y_r - 17'(qy_nxt) * 17'd100;
    if (ry_nxt >= 17'd100) begin
      qy_nxt = qy_nxt + 11'd1;
    end
    b_nxt  = s2_p1_r[DIV146097_K +: 11];
    r1_nxt = s2_x1_r - 28'(b_nxt) * 28'd146097;
    if (r1_nxt >= 28'd146097) begin
      b_nxt  = b_nxt + 11'd1;
      r1_nxt = r1_nxt - 28'd146097;
    end
    secs_nxt = s2_pt_r[DIV1000_K +: 17];
    rms_nxt  = s2_t_r - 27'(secs_nxt) * 27'd1000;
    if (rms_nxt >= 27'd1000) begin
      secs_nxt = secs_nxt + 17'd1;
      rms_nxt  = rms_nxt - 27'd1000;
    end
  end

  // stage 4 date checks
  logic       leap;
  logic       day_bad;
  logic [1:0] st0_nxt;
  always_comb begin
    leap    = (s3_year_lo_r == 2'd0) && (s3_c100_r || (s3_qyr_lo_r == 2'd0));
    day_bad = (s3_day_r == 5'd0) || (s3_day_r > month_len(s3_mon_r, leap));
    priority if (s3_mon_bad_r) begin
      st0_nxt = ST_BAD_MONTH;
    end else if (s3_year_big_r) begin
      st0_nxt = ST_BAD_YEAR;
    end else if (day_bad || s3_time_bad_r) begin
      st0_nxt = ST_BAD_FIELD;
    end else begin
      st0_nxt = ST_OK;
    end
  end

  // stage 5 corrections
  logic [7:0]  d_nxt;
  logic [17:0] r2_nxt;
  logic [11:0] mint_nxt;
  logic [16:0] rsec_nxt;
  logic [25:0] jd_nxt;
  always_comb begin
    jd_nxt = s4_jda_r + 26'(s4_jdb_r) - 26'(s4_qy_r) - JD_OFS_OUT;
    d_nxt  = s4_p2_r[DIV1461_K +: 8];
    r2_nxt = s4_x2_r - 18'(d_nxt) * 18'd1461;
    if (r2_nxt >= 18'd1461) begin
      d_nxt  = d_nxt + 8'd1;
      r2_nxt = r2_nxt - 18'd1461;
    end
    mint_nxt = s4_psec_r[DIV60_K +: 12];
    rsec_nxt = s4_secs_r - 17'(mint_nxt) * 17'd60;
    if (rsec_nxt >= 17'd60) begin
      mint_nxt = mint_nxt + 12'd1;
      rsec_nxt = rsec_nxt - 17'd60;
    end
  end

  // stage 7 corrections
  logic [3:0]  m_nxt;
  logic [10:0] r3_nxt;
  logic [11:0] hour_nxt;
  logic [11:0] rmin_nxt;
  always_comb begin
    m_nxt  = s6_p3_r[DIV153_K +: 4];
    r3_nxt = s6_x3_r - 11'(m_nxt) * 11'd153;
    if (r3_nxt >= 11'd153) begin
      m_nxt  = m_nxt + 4'd1;
      r3_nxt = r3_nxt - 11'd153;
    end
    hour_nxt = s6_pmin_r[DIV60_K +: 12];
    rmin_nxt = s6_mint_r - hour_nxt * 12'd60;
    if (rmin_nxt >= 12'd60) begin
      hour_nxt = hour_nxt + 12'd1;
      rmin_nxt = rmin_nxt - 12'd60;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
      s6_v_r <= 1'b0;
      s7_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_valid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
      s5_v_r <= s4_v_r;
      s6_v_r <= s5_v_r;
      s7_v_r <= s6_v_r;
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1: field checks and offsets
      s1_op_r       <= in_word.opcode;
      s1_mon_bad_r  <= (in_word.month == 4'd0) || (in_word.month > 4'd12);
      s1_time_bad_r <= (in_word.hour > 5'd23) || (in_word.minute > 6'd59) ||
                       (in_word.second > 6'd59) || (in_word.millisecond > 10'd999);
      s1_year_big_r <= (32'(in_word.year) >= (32'd1 << YEAR_BITS));
      s1_year_r     <= in_word.year;
      s1_day_r      <= in_word.day_of_month;
      s1_mon_r      <= in_word.month;
      s1_mm_r       <= in_word.month + (a_flag ? 4'd12 : 4'd0) - 4'd3;
      s1_y_r        <= 17'(YEAR_OFS) + 17'(in_word.year) - 17'(a_flag);
      s1_hm_r       <= 11'(in_word.hour) * 11'd60 + 11'(in_word.minute);
      s1_sec_r      <= in_word.second;
      s1_ms_r       <= in_word.millisecond;
      s1_x1_r       <= {a_cal, 2'b11};
      s1_t_r        <= in_word.time_ms;
      s1_tbad_r     <= (in_word.time_ms >= MS_PER_DAY);
      // stage 2: reciprocal products
      s2_op_r       <= s1_op_r;
      s2_mon_bad_r  <= s1_mon_bad_r;
      s2_time_bad_r <= s1_time_bad_r;
      s2_year_big_r <= s1_year_big_r;
      s2_year_r     <= s1_year_r;
      s2_day_r      <= s1_day_r;
      s2_mon_r      <= s1_mon_r;
      s2_mm_r       <= s1_mm_r;
      s2_y_r        <= s1_y_r;
      s2_pyr_r      <= 35'(s1_year_r) * 35'(DIV100_M);
      s2_py_r       <= 35'(s1_y_r) * 35'(DIV100_M);
      s2_hms_r      <= 17'(s1_hm_r) * 17'd60 + 17'(s1_sec_r);
      s2_ms_r       <= s1_ms_r;
      s2_p1_r       <= 57'(s1_x1_r) * 57'(DIV146097_M);
      s2_x1_r       <= s1_x1_r;
      s2_pt_r       <= 55'(s1_t_r) * 55'(DIV1000_M);
      s2_t_r        <= s1_t_r;
      s2_tbad_r     <= s1_tbad_r;
      // stage 3: quotients and remainders
      s3_op_r       <= s2_op_r;
      s3_mon_bad_r  <= s2_mon_bad_r;
      s3_time_bad_r <= s2_time_bad_r;
      s3_year_big_r <= s2_year_big_r;
      s3_year_lo_r  <= s2_year_r[1:0];
      s3_day_r      <= s2_day_r;
      s3_mon_r      <= s2_mon_r;
      s3_mm_r       <= s2_mm_r;
      s3_y_r        <= s2_y_r;
      s3_c100_r     <= (ryr_nxt != 17'd0);
      s3_qyr_lo_r   <= qyr_nxt[1:0];
      s3_qy_r       <= qy_nxt;
      s3_tms_r      <= 27'(s2_hms_r) * 27'd1000 + 27'(s2_ms_r);
      s3_b_r        <= b_nxt;
      s3_c_r        <= r1_nxt[17:2];
      s3_secs_r     <= secs_nxt;
      s3_msr_r      <= rms_nxt[9:0];
      s3_tbad_r     <= s2_tbad_r;
      // stage 4: day sums and second products
      s4_op_r       <= s3_op_r;
      s4_st0_r      <= st0_nxt;
      s4_jda_r      <= 26'(s3_y_r) * 26'd365 + 26'(s3_y_r >> 2);
      s4_jdb_r      <= 10'(s3_day_r) + 10'(month_start(s3_mm_r)) + 10'(s3_qy_r >> 2);
      s4_qy_r       <= s3_qy_r;
      s4_tms_r      <= s3_tms_r;
      s4_b_r        <= s3_b_r;
      s4_x2_r       <= {s3_c_r, 2'b11};
      s4_p2_r       <= 37'({s3_c_r, 2'b11}) * 37'(DIV1461_M);
      s4_psec_r     <= 35'(s3_secs_r) * 35'(DIV60_M);
      s4_secs_r     <= s3_secs_r;
      s4_msr_r      <= s3_msr_r;
      s4_tbad_r     <= s3_tbad_r;
      // stage 5: day number, century year and minutes
      s5_op_r       <= s4_op_r;
      s5_st0_r      <= s4_st0_r;
      s5_jd_r       <= jd_nxt[24:0];
      s5_tms_r      <= s4_tms_r;
      s5_b_r        <= s4_b_r;
      s5_d_r        <= d_nxt;
      s5_e_r        <= r2_nxt[10:2];
      s5_mint_r     <= mint_nxt;
      s5_sec_r      <= rsec_nxt[5:0];
      s5_msr_r      <= s4_msr_r;
      s5_tbad_r     <= s4_tbad_r;
      // stage 6: month and hour products
      s6_op_r       <= s5_op_r;
      s6_st0_r      <= s5_st0_r;
      s6_jd_r       <= s5_jd_r;
      s6_tms_r      <= s5_tms_r;
      s6_b_r        <= s5_b_r;
      s6_d_r        <= s5_d_r;
      s6_x3_r       <= 11'(s5_e_r) * 11'd5 + 11'd2;
      s6_p3_r       <= 23'(11'(s5_e_r) * 11'd5 + 11'd2) * 23'(DIV153_M);
      s6_pmin_r     <= 35'(s5_mint_r) * 35'(DIV60_M);
      s6_mint_r     <= s5_mint_r;
      s6_sec_r      <= s5_sec_r;
      s6_msr_r      <= s5_msr_r;
      s6_tbad_r     <= s5_tbad_r;
      // stage 7: month index and clock fields
      s7_op_r       <= s6_op_r;
      s7_st0_r      <= s6_st0_r;
      s7_jd_r       <= s6_jd_r;
      s7_tms_r      <= s6_tms_r;
      s7_b_r        <= s6_b_r;
      s7_d_r        <= s6_d_r;
      s7_m_r        <= m_nxt;
      s7_r3_r       <= r3_nxt[7:0];
      s7_hour_r     <= hour_nxt[4:0];
      s7_min_r      <= rmin_nxt[5:0];
      s7_sec_r      <= s6_sec_r;
      s7_msr_r      <= s6_msr_r;
      s7_tbad_r     <= s6_tbad_r;
    end
  end

  // final year, month, day and result word
  logic        hi_m;
  logic [17:0] ysum;
  logic [17:0] yval;
  logic        ybad;
  logic [1:0]  st1;
  logic [15:0] day_q;
  always_comb begin
    hi_m  = (s7_m_r >= 4'd10);
    ysum  = 18'(s7_b_r) * 18'd100 + 18'(s7_d_r) + 18'(hi_m);
    yval  = ysum - YEAR_OFS;
    ybad  = (ysum < YEAR_OFS) || (32'(yval) >= (32'd1 << YEAR_BITS));
    day_q = (16'(s7_r3_r) * 16'd205) >> 10;
    priority if (ybad) begin
      st1 = ST_BAD_YEAR;
    end else if (s7_tbad_r) begin
      st1 = ST_BAD_FIELD;
    end else begin
      st1 = ST_OK;
    end
    res_word = '0;
    if (s7_op_r == OP_TO_JD) begin
      res_word.status = s7_st0_r;
      if (s7_st0_r == ST_OK) begin
        res_word.out_jd_day  = s7_jd_r;
        res_word.out_time_ms = s7_tms_r;
      end
    end else begin
      res_word.status = st1;
      if (st1 == ST_OK) begin
        res_word.out_year        = yval[15:0];
        res_word.out_month       = hi_m ? (s7_m_r - 4'd9) : (s7_m_r + 4'd3);
        res_word.out_day         = 5'(day_q) + 5'd1;
        res_word.out_hour        = s7_hour_r;
        res_word.out_minute      = s7_min_r;
        res_word.out_second      = s7_sec_r;
        res_word.out_millisecond = s7_msr_r;
      end
    end
  end

  assign res_valid = s7_v_r;

endmodule

`default_nettype wire

// ----- test/jdc_checker.sv -----
// jdc_checker: watches both channels of julian_day_converter, predicts and compares words
// depends on jdc_pkg
`timescale 1ns / 1ps

module jdc_checker (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_stall,
  input  jdc_pkg::in_t  in_data,
  input  logic          out_valid,
  input  logic          out_stall,
  input  jdc_pkg::out_t out_data,
  output int            fail_count,
  output int            pending
);
  import jdc_pkg::*;

  out_t expected_q[$];

  function automatic bit leap_year(longint y);
    if (y % 400 == 0) return 1;
    if (y % 100 == 0) return 0;
    return y % 4 == 0;
  endfunction

  // calendar conversion in both directions, 64-bit integer arithmetic
  function automatic out_t convert(in_t w);
    out_t r;
    longint lim, a, y, m, jd, b, c, d, e, yr, t;
    r = '0;
    if (w.opcode == OP_TO_JD) begin
      if (w.month < 1 || w.month > 12) begin
        r.status = ST_BAD_MONTH;
        return r;
      end
      if (longint'(w.year) >= (longint'(1) << YEAR_BITS)) begin
        r.status = ST_BAD_YEAR;
        return r;
      end
      case (w.month)
        2: lim = leap_year(w.year) ? 29 : 28;
        4, 6, 9, 11: lim = 30;
        default: lim = 31;
      endcase
      if (w.day_of_month < 1 || w.day_of_month > lim || w.hour > 23 || w.minute > 59 ||
          w.second > 59 || w.millisecond > 999) begin
        r.status = ST_BAD_FIELD;
        return r;
      end
      a = (14 - w.month) / 12;
      y = 4800 + w.year - a;
      m = w.month + 12 * a - 3;
      jd = w.day_of_month + (153 * m + 2) / 5 + 365 * y + y / 4 - y / 100 + y / 400 - 32045;
      r.status = ST_OK;
      r.out_jd_day = jd[24:0];
      t = ((longint'(w.hour) * 60 + w.minute) * 60 + w.second) * 1000 + w.millisecond;
      r.out_time_ms = t[26:0];
    end else begin
      a = longint'(w.jd_day) + 32044;
      b = (4 * a + 3) / 146097;
      c = a - (146097 * b) / 4;
      d = (4 * c + 3) / 1461;
      e = c - (1461 * d) / 4;
      m = (5 * e + 2) / 153;
      yr = 100 * b + d + m / 10 - 4800;
      if (yr < 0 || yr >= (longint'(1) << YEAR_BITS)) begin
        r.status = ST_BAD_YEAR;
        return r;
      end
      t = w.time_ms;
      if (t >= 86400000) begin
        r.status = ST_BAD_FIELD;
        return r;
      end
      r.status = ST_OK;
      r.out_year = yr[15:0];
      lim = m + 3 - 12 * (m / 10);
      r.out_month = lim[3:0];
      lim = e - (153 * m + 2) / 5 + 1;
      r.out_day = lim[4:0];
      r.out_millisecond = 10'(t % 1000);
      t = t / 1000;
      r.out_second = 6'(t % 60);
      t = t / 60;
      r.out_minute = 6'(t % 60);
      r.out_hour = 5'(t / 60 % 24);
    end
    return r;
  endfunction

  assign pending = expected_q.size();

  // predict on accepted input, compare on accepted output
  always @(posedge clk) begin
    out_t exp_w;
    if (!rst_n) begin
      fail_count <= 0;
    end else begin
      if (in_valid && !in_stall) expected_q.insert(expected_q.size(), convert(in_data));
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $error("unexpected word %h", out_data);
          fail_count <= fail_count + 1;
        end else begin
          exp_w = expected_q.pop_front();
          if (exp_w != out_data) begin
            fail_count <= fail_count + 1;
            if (exp_w.status != out_data.status)
              $error("status exp %0d got %0d", exp_w.status, out_data.status);
            if (exp_w.out_jd_day != out_data.out_jd_day)
              $error("out_jd_day exp %0d got %0d", exp_w.out_jd_day, out_data.out_jd_day);
            if (exp_w.out_time_ms != out_data.out_time_ms)
              $error("out_time_ms exp %0d got %0d", exp_w.out_time_ms, out_data.out_time_ms);
            if (exp_w.out_year != out_data.out_year)
              $error("out_year exp %0d got %0d", exp_w.out_year, out_data.out_year);
            if (exp_w.out_month != out_data.out_month)
              $error("out_month exp %0d got %0d", exp_w.out_month, out_data.out_month);
            if (exp_w.out_day != out_data.out_day)
              $error("out_day exp %0d got %0d", exp_w.out_day, out_data.out_day);
            if (exp_w.out_hour != out_data.out_hour)
              $error("out_hour exp %0d got %0d", exp_w.out_hour, out_data.out_hour);
            if (exp_w.out_minute != out_data.out_minute)
              $error("out_minute exp %0d got %0d", exp_w.out_minute, out_data.out_minute);
            if (exp_w.out_second != out_data.out_second)
              $error("out_second exp %0d got %0d", exp_w.out_second, out_data.out_second);
            if (exp_w.out_millisecond != out_data.out_millisecond)
              $error("out_millisecond exp %0d got %0d", exp_w.out_millisecond,
                     out_data.out_millisecond);
          end
        end
      end
    end
  end

endmodule

// ----- test/tb_julian_day_converter.sv -----
// tb_julian_day_converter: stimulus and verdict for julian_day_converter
// depends on jdc_pkg, jdc_checker and the design
`timescale 1ns / 1ps

module tb_julian_day_converter;
  import jdc_pkg::*;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_t  in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;
  int   fail_count;
  int   pending;
  bit   hold_off;

  julian_day_converter dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  jdc_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("Regression FAIL");
    $finish;
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // raw random word
  function automatic in_t rand_word();
    logic [127:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom};
    return in_t'(raw[$bits(in_t)-1:0]);
  endfunction

  // date word, mostly well formed
  function automatic in_t date_word(bit legal);
    in_t w;
    w = rand_word();
    w.opcode = OP_TO_JD;
    if (legal) begin
      w.month = 4'($urandom_range(1, 12));
      w.day_of_month = 5'($urandom_range(1, 28 + $urandom_range(0, 3)));
      w.hour = 5'($urandom_range(0, 23));
      w.minute = 6'($urandom_range(0, 59));
      w.second = 6'($urandom_range(0, 59));
      w.millisecond = 10'($urandom_range(0, 999));
      if ($urandom_range(0, 3) == 0) w.year = 16'($urandom_range(1900, 2400));
    end
    return w;
  endfunction

  function automatic in_t day_word(bit legal);
    in_t w;
    w = rand_word();
    w.opcode = OP_TO_CAL;
    if (legal) begin
      w.jd_day = 25'($urandom_range(0, 25_700_000));
      w.time_ms = 27'($urandom_range(0, 86_399_999));
    end
    return w;
  endfunction

  function automatic in_t mk_date(int y, int mo, int d, int h, int mi, int s, int ms);
    in_t w;
    w = '0;
    w.opcode = OP_TO_JD;
    w.year = 16'(y); w.month = 4'(mo); w.day_of_month = 5'(d);
    w.hour = 5'(h); w.minute = 6'(mi); w.second = 6'(s); w.millisecond = 10'(ms);
    return w;
  endfunction

  function automatic in_t mk_day(int jd, int t);
    in_t w;
    w = '0;
    w.opcode = OP_TO_CAL;
    w.jd_day = 25'(jd); w.time_ms = 27'(t);
    return w;
  endfunction

  // offer one word and wait for acceptance; valid drops only over a gap
  task automatic send(in_t w);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // receiver stalls
  initial begin
    int g;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_off) begin
        out_stall <= 1'b1;
        repeat (60) @(posedge clk);
        hold_off = 0;
      end
      g = gap_len();
      if (g > 0) begin
        out_stall <= 1'b1;
        repeat (g) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
    end
  end

  initial begin
    in_t w;
    int wait_cnt;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    hold_off = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes and every status path
    send(mk_date(0, 1, 1, 0, 0, 0, 0));
    send(mk_date(65535, 12, 31, 23, 59, 59, 999));
    send(mk_date(2000, 2, 29, 12, 30, 30, 500));
    send(mk_date(1900, 2, 29, 0, 0, 0, 0));
    send(mk_date(2024, 2, 29, 0, 0, 0, 0));
    send(mk_date(2023, 2, 29, 0, 0, 0, 0));
    send(mk_date(2023, 4, 31, 0, 0, 0, 0));
    send(mk_date(2023, 0, 1, 0, 0, 0, 0));
    send(mk_date(2023, 13, 1, 0, 0, 0, 0));
    send(mk_date(2023, 15, 31, 31, 63, 63, 1023));
    send(mk_date(2023, 5, 0, 0, 0, 0, 0));
    send(mk_date(2023, 5, 1, 24, 0, 0, 0));
    send(mk_date(2023, 5, 1, 0, 60, 0, 0));
    send(mk_date(2023, 5, 1, 0, 0, 60, 0));
    send(mk_date(2023, 5, 1, 0, 0, 0, 1000));
    send(mk_day(0, 0));
    send(mk_day(1721119, 0));
    send(mk_day(1721120, 86399999));
    send(mk_day(2451545, 43200000));
    send(mk_day(25657000, 0));
    send(mk_day(25657500, 0));
    send(mk_day(33554431, 134217727));
    send(mk_day(2451545, 86400000));
    send(mk_day(2451545, 134217727));

    // random: mostly legal words of both kinds, rest raw noise
    for (int i = 0; i < 450; i++) begin
      if (i == 200) hold_off = 1;
      case ($urandom_range(0, 9))
        0: w = rand_word();
        1, 2, 3, 4: w = date_word($urandom_range(0, 5) != 0);
        default: w = day_word($urandom_range(0, 5) != 0);
      endcase
      send(w);
    end
    in_valid <= 1'b0;

    wait_cnt = 0;
    while (pending != 0 && wait_cnt < 100000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (20) @(posedge clk);
    if (pending == 0 && fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/jdc_pkg.sv
design/jdc_datapath.sv
design/julian_day_converter.sv
test/jdc_checker.sv
test/tb_julian_day_converter.sv
